### sv/ordered_key_value_table_unit_assert.svh
// Assertion macros used by the ordered key/value table checker
`ifndef ORDERED_KEY_VALUE_TABLE_UNIT_ASSERT_SVH
`define ORDERED_KEY_VALUE_TABLE_UNIT_ASSERT_SVH

// Check a consequence in the same cycle as its antecedent
`define OKVT_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("ordered key/value table check failed");

// Check a consequence in the cycle after its antecedent
`define OKVT_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("ordered key/value table check failed");

`endif

### sv/okvt_pkg.sv
// Shared types and constants of the ordered key/value table
package okvt_pkg;

  localparam int unsigned FUNC_W  = 3;
  localparam int unsigned KEY_W   = 32;
  localparam int unsigned VAL_W   = 32;
  localparam int unsigned POS_W   = 4;
  localparam int unsigned COUNT_W = 5;

  // Operation codes
  localparam logic [FUNC_W-1:0] FUNC_SET     = 3'd0;
  localparam logic [FUNC_W-1:0] FUNC_GET     = 3'd1;
  localparam logic [FUNC_W-1:0] FUNC_DELETE  = 3'd2;
  localparam logic [FUNC_W-1:0] FUNC_CLEAR   = 3'd3;
  localparam logic [FUNC_W-1:0] FUNC_READ_AT = 3'd4;

  // Sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_CMP,
    ST_SHIFT_RD,
    ST_SHIFT_WR,
    ST_FETCH
  } state_e;

  // Fields of one result transaction
  typedef struct packed {
    logic             hit;
    logic             full_error;
    logic [VAL_W-1:0] value;
    logic [KEY_W-1:0] key;
    logic [POS_W-1:0] position;
  } res_t;

endpackage

### sv/okvt_ram.sv
// Generic single-write, single-read RAM with registered read data
module okvt_ram #(
  parameter int unsigned WIDTH = 64,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AddrW = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // Registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### sv/ordered_key_value_table_unit.sv
// Top level of the ordered key/value table with linear search
// Usage:
//   Command channel: drive func_i, key_i, value_i and position_i and raise start;
//   the transaction is taken at a rising edge with start high and busy low.
//   Result channel: done_o is high for exactly one cycle with hit_o, full_error_o,
//   value_out_o, key_out_o, position_out_o and entry_count_o; the receiver cannot
//   hold it off, so it must take the result in that cycle.
// Timing:
//   One transaction is in flight at a time; busy stays high until it is done.
//   Clear, unknown codes, an operation on an empty table and a read-at past the
//   end finish without leaving idle; a valid read-at goes through the fetch state.
//   Set, get and delete scan the entries through the single RAM read port and
//   one 32-bit key comparator, a read and a compare state per entry visited.
//   Delete then moves every later entry down one place, with a read state and
//   a write-back state per entry.
//   The result strobe is registered and rises in the cycle after the last step.
// Reset:
//   rst_ni clears the entry count and the sequencer; the table is then empty.
//   Store contents are not cleared: only positions below the count are read.
module ordered_key_value_table_unit #(
  parameter int unsigned DEPTH = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start,
  output logic                          busy,
  input  logic [okvt_pkg::FUNC_W-1:0]   func_i,
  input  logic [okvt_pkg::KEY_W-1:0]    key_i,
  input  logic [okvt_pkg::VAL_W-1:0]    value_i,
  input  logic [okvt_pkg::POS_W-1:0]    position_i,
  output logic                          done_o,
  output logic                          hit_o,
  output logic                          full_error_o,
  output logic [okvt_pkg::VAL_W-1:0]    value_out_o,
  output logic [okvt_pkg::KEY_W-1:0]    key_out_o,
  output logic [okvt_pkg::POS_W-1:0]    position_out_o,
  output logic [okvt_pkg::COUNT_W-1:0]  entry_count_o
);

  localparam int unsigned IdxW  = $clog2(DEPTH);
  localparam int unsigned CntW  = $clog2(DEPTH + 1);
  localparam int unsigned CmpW  = (CntW > okvt_pkg::POS_W) ? CntW : okvt_pkg::POS_W;
  localparam int unsigned WordW = okvt_pkg::KEY_W + okvt_pkg::VAL_W;

  okvt_pkg::state_e state_q, state_d;

  logic [okvt_pkg::FUNC_W-1:0] op_q;
  logic [okvt_pkg::KEY_W-1:0]  key_q;
  logic [okvt_pkg::VAL_W-1:0]  val_q;
  logic [okvt_pkg::POS_W-1:0]  pos_q;
  logic [IdxW-1:0]             idx_q, idx_d;
  logic [CntW-1:0]             count_q, count_d;
  logic                        done_q, done_d;
  okvt_pkg::res_t              res_q, res_d;
  logic                        res_load;

  logic                        accept;
  logic                        ram_we, ram_re;
  logic [IdxW-1:0]             ram_waddr, ram_raddr;
  logic [WordW-1:0]            ram_wdata, ram_rdata;
  logic [okvt_pkg::KEY_W-1:0]  rd_key;
  logic [okvt_pkg::VAL_W-1:0]  rd_val;
  logic                        match, not_last, is_empty, is_full, pos_ok;

  assign accept   = start && !busy;
  assign busy     = (state_q != okvt_pkg::ST_IDLE);
  assign rd_key   = ram_rdata[WordW-1:okvt_pkg::VAL_W];
  assign rd_val   = ram_rdata[okvt_pkg::VAL_W-1:0];

  // Shared key comparator and index bounds
  assign match    = (rd_key == key_q);
  assign not_last = ((CntW'(idx_q) + CntW'(1)) < count_q);
  assign is_empty = (count_q == '0);
  assign is_full  = (count_q == CntW'(DEPTH));
  assign pos_ok   = (CmpW'(position_i) < CmpW'(count_q));

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      okvt_pkg::ST_IDLE: begin
        if (accept) begin
          case (func_i)
            okvt_pkg::FUNC_SET,
            okvt_pkg::FUNC_GET,
            okvt_pkg::FUNC_DELETE: begin
              state_d = is_empty ? okvt_pkg::ST_IDLE : okvt_pkg::ST_READ;
            end
            okvt_pkg::FUNC_READ_AT: begin
              state_d = pos_ok ? okvt_pkg::ST_FETCH : okvt_pkg::ST_IDLE;
            end
            default: begin
              state_d = okvt_pkg::ST_IDLE;
            end
          endcase
        end
      end
      okvt_pkg::ST_READ: begin
        state_d = okvt_pkg::ST_CMP;
      end
      okvt_pkg::ST_CMP: begin
        if (match) begin
          state_d = (op_q == okvt_pkg::FUNC_DELETE && not_last) ?
                    okvt_pkg::ST_SHIFT_RD : okvt_pkg::ST_IDLE;
        end else begin
          state_d = not_last ? okvt_pkg::ST_READ : okvt_pkg::ST_IDLE;
        end
      end
      okvt_pkg::ST_SHIFT_RD: begin
        state_d = okvt_pkg::ST_SHIFT_WR;
      end
      okvt_pkg::ST_SHIFT_WR: begin
        state_d = not_last ? okvt_pkg::ST_SHIFT_RD : okvt_pkg::ST_IDLE;
      end
      okvt_pkg::ST_FETCH: begin
        state_d = okvt_pkg::ST_IDLE;
      end
      default: begin
        state_d = okvt_pkg::ST_IDLE;
      end
    endcase
  end

  // Sequencer outputs: RAM control, counters and result load
  always_comb begin
    ram_we    = 1'b0;
    ram_re    = 1'b0;
    ram_waddr = idx_q;
    ram_raddr = idx_q;
    ram_wdata = {key_q, val_q};
    idx_d     = idx_q;
    count_d   = count_q;
    done_d    = 1'b0;
    res_load  = 1'b0;
    res_d     = '{hit: 1'b0, full_error: 1'b0, value: '0, key: key_q, position: '0};
    case (state_q)
      okvt_pkg::ST_IDLE: begin
        if (accept) begin
          idx_d     = '0;
          res_d.key = key_i;
          case (func_i)
            okvt_pkg::FUNC_SET,
            okvt_pkg::FUNC_GET,
            okvt_pkg::FUNC_DELETE: begin
              if (is_empty) begin
                // Nothing to scan: a set appends at the first place
                if (func_i == okvt_pkg::FUNC_SET) begin
                  ram_we    = 1'b1;
                  ram_waddr = '0;
                  ram_wdata = {key_i, value_i};
                  count_d   = CntW'(1);
                end
                res_load = 1'b1;
                done_d   = 1'b1;
              end
            end
            okvt_pkg::FUNC_CLEAR: begin
              count_d  = '0;
              res_load = 1'b1;
              done_d   = 1'b1;
            end
            okvt_pkg::FUNC_READ_AT: begin
              if (pos_ok) begin
                ram_re    = 1'b1;
                ram_raddr = IdxW'(position_i);
              end else begin
                res_d.key = '0;
                res_load  = 1'b1;
                done_d    = 1'b1;
              end
            end
            default: begin
              res_load = 1'b1;
              done_d   = 1'b1;
            end
          endcase
        end
      end
      okvt_pkg::ST_READ: begin
        ram_re = 1'b1;
      end
      okvt_pkg::ST_CMP: begin
        if (match) begin
          res_d.hit      = 1'b1;
          res_d.position = okvt_pkg::POS_W'(idx_q);
          res_load       = 1'b1;
          case (op_q)
            okvt_pkg::FUNC_SET: begin
              ram_we      = 1'b1;
              res_d.value = val_q;
              done_d      = 1'b1;
            end
            okvt_pkg::FUNC_DELETE: begin
              res_d.value = rd_val;
              // Close the gap, or just drop the last entry
              if (not_last) begin
                idx_d = idx_q + IdxW'(1);
              end else begin
                count_d = count_q - CntW'(1);
                done_d  = 1'b1;
              end
            end
            default: begin
              res_d.value = rd_val;
              done_d      = 1'b1;
            end
          endcase
        end else if (not_last) begin
          idx_d = idx_q + IdxW'(1);
        end else begin
          // Key absent: a set appends unless the table is full
          if (op_q == okvt_pkg::FUNC_SET) begin
            if (is_full) begin
              res_d.full_error = 1'b1;
            end else begin
              ram_we    = 1'b1;
              ram_waddr = IdxW'(count_q);
              count_d   = count_q + CntW'(1);
            end
          end
          res_load = 1'b1;
          done_d   = 1'b1;
        end
      end
      okvt_pkg::ST_SHIFT_RD: begin
        ram_re = 1'b1;
      end
      okvt_pkg::ST_SHIFT_WR: begin
        ram_we    = 1'b1;
        ram_waddr = idx_q - IdxW'(1);
        ram_wdata = ram_rdata;
        if (not_last) begin
          idx_d = idx_q + IdxW'(1);
        end else begin
          count_d = count_q - CntW'(1);
          done_d  = 1'b1;
        end
      end
      okvt_pkg::ST_FETCH: begin
        res_d.hit      = 1'b1;
        res_d.key      = rd_key;
        res_d.value    = rd_val;
        res_d.position = pos_q;
        res_load       = 1'b1;
        done_d         = 1'b1;
      end
      default: begin
        done_d = 1'b0;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= okvt_pkg::ST_IDLE;
      idx_q   <= '0;
      count_q <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      idx_q   <= idx_d;
      count_q <= count_d;
      done_q  <= done_d;
    end
  end

  // Hold the command fields and the result fields
  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q  <= func_i;
      key_q <= key_i;
      val_q <= value_i;
      pos_q <= position_i;
    end
    if (res_load) begin
      res_q <= res_d;
    end
  end

  okvt_ram #(
    .WIDTH (WordW),
    .DEPTH (DEPTH)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign done_o         = done_q;
  assign hit_o          = res_q.hit;
  assign full_error_o   = res_q.full_error;
  assign value_out_o    = res_q.value;
  assign key_out_o      = res_q.key;
  assign position_out_o = res_q.position;
  assign entry_count_o  = okvt_pkg::COUNT_W'(count_q);

endmodule

### sv/okvt_checker.sv
// Port-level checker for the ordered key/value table, bound to the top level
`include "ordered_key_value_table_unit_assert.svh"

module okvt_checker (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         start,
  input logic                         busy,
  input logic                         done_o,
  input logic                         hit_o,
  input logic                         full_error_o,
  input logic [okvt_pkg::VAL_W-1:0]   value_out_o,
  input logic [okvt_pkg::POS_W-1:0]   position_out_o
);

  // A refused set never reports a hit
  `OKVT_ASSERT_SAME(a_hit_full_excl, done_o, !(hit_o && full_error_o))

  // A miss reports zero value and zero position
  `OKVT_ASSERT_SAME(a_miss_zero, done_o && !hit_o, value_out_o == '0 && position_out_o == '0)

  // An accepted transaction either keeps the block busy or answers next cycle
  `OKVT_ASSERT_NEXT(a_accept_progress, start && !busy, busy || done_o)

  // The block only turns busy on an accepted transaction
  `OKVT_ASSERT_SAME(a_busy_cause, $rose(busy), $past(start))

endmodule

bind ordered_key_value_table_unit okvt_checker u_okvt_checker (.*);

### tb/tb_ordered_key_value_table_unit.sv
// Self-checking testbench for the ordered key/value table unit
module tb_ordered_key_value_table_unit;
  timeunit 1ns;
  timeprecision 1ps;

  import okvt_pkg::*;

  localparam int unsigned TABLE_DEPTH   = 16;
  localparam int unsigned CLK_PERIOD    = 10;
  localparam int unsigned KEY_POOL      = 24;
  localparam int unsigned SETTLE_CYCLES = 4 * TABLE_DEPTH + 8;
  localparam longint unsigned CYCLE_LIMIT = 1_000_000;

  // Codes with no operation behind them
  localparam logic [FUNC_W-1:0] FUNC_SPARE_LO = 3'd5;
  localparam logic [FUNC_W-1:0] FUNC_SPARE_HI = 3'd7;

  typedef struct packed {
    logic               hit;
    logic               full_error;
    logic [VAL_W-1:0]   value;
    logic [KEY_W-1:0]   key;
    logic [POS_W-1:0]   position;
    logic [COUNT_W-1:0] count;
  } table_reply_t;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               start = 1'b0;
  logic               busy;
  logic [FUNC_W-1:0]  func_i = FUNC_GET;
  logic [KEY_W-1:0]   key_i = '0;
  logic [VAL_W-1:0]   value_i = '0;
  logic [POS_W-1:0]   position_i = '0;
  logic               done_o;
  logic               hit_o;
  logic               full_error_o;
  logic [VAL_W-1:0]   value_out_o;
  logic [KEY_W-1:0]   key_out_o;
  logic [POS_W-1:0]   position_out_o;
  logic [COUNT_W-1:0] entry_count_o;

  // Shadow copy of the table contents
  logic [KEY_W-1:0] kept_keys [TABLE_DEPTH];
  logic [VAL_W-1:0] kept_vals [TABLE_DEPTH];
  int unsigned      held = 0;

  table_reply_t replies_owed[$];

  int unsigned     sender_idle_pct = 0;
  int unsigned     mismatch_count = 0;
  int unsigned     reply_total = 0;
  int unsigned     hit_tally = 0;
  int unsigned     refusal_tally = 0;
  int unsigned     op_tally [8];
  longint unsigned cycle_count = 0;

  ordered_key_value_table_unit #(
    .DEPTH(TABLE_DEPTH)
  ) uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start         (start),
    .busy          (busy),
    .func_i        (func_i),
    .key_i         (key_i),
    .value_i       (value_i),
    .position_i    (position_i),
    .done_o        (done_o),
    .hit_o         (hit_o),
    .full_error_o  (full_error_o),
    .value_out_o   (value_out_o),
    .key_out_o     (key_out_o),
    .position_out_o(position_out_o),
    .entry_count_o (entry_count_o)
  );

  always begin
    #(CLK_PERIOD / 2) clk_i = 1'b1;
    #(CLK_PERIOD / 2) clk_i = 1'b0;
  end

  // Apply one operation to the shadow table and return the reply it owes
  function automatic table_reply_t apply_table_op(input logic [FUNC_W-1:0] op,
                                                  input logic [KEY_W-1:0] k,
                                                  input logic [VAL_W-1:0] v,
                                                  input logic [POS_W-1:0] p);
    table_reply_t r;
    int           slot;
    int unsigned  i;
    r     = '0;
    r.key = k;
    slot  = -1;
    for (i = 0; i < held; i++) begin
      if (slot < 0 && kept_keys[i] == k) slot = i;
    end
    case (op)
      FUNC_SET: begin
        if (slot >= 0) begin
          kept_vals[slot] = v;
          r.hit      = 1'b1;
          r.value    = v;
          r.position = POS_W'(slot);
        end else if (held < TABLE_DEPTH) begin
          kept_keys[held] = k;
          kept_vals[held] = v;
          held++;
        end else begin
          r.full_error = 1'b1;
        end
      end
      FUNC_GET: begin
        if (slot >= 0) begin
          r.hit      = 1'b1;
          r.value    = kept_vals[slot];
          r.position = POS_W'(slot);
        end
      end
      FUNC_DELETE: begin
        if (slot >= 0) begin
          r.hit      = 1'b1;
          r.value    = kept_vals[slot];
          r.position = POS_W'(slot);
          // close the gap, keeping later entries in order
          for (i = slot; i + 1 < held; i++) begin
            kept_keys[i] = kept_keys[i + 1];
            kept_vals[i] = kept_vals[i + 1];
          end
          held--;
        end
      end
      FUNC_CLEAR: begin
        held = 0;
      end
      FUNC_READ_AT: begin
        r.key = '0;
        if (p < held) begin
          r.hit      = 1'b1;
          r.key      = kept_keys[p];
          r.value    = kept_vals[p];
          r.position = p;
        end
      end
      default: begin
      end
    endcase
    r.count = COUNT_W'(held);
    return r;
  endfunction

  task automatic apply_reset();
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
  endtask

  // Issue one command transaction; start stays high afterwards for the next one
  task automatic send_command(input logic [FUNC_W-1:0] op, input logic [KEY_W-1:0] k,
                              input logic [VAL_W-1:0] v, input logic [POS_W-1:0] p);
    while ($urandom_range(99) < sender_idle_pct) begin
      start <= 1'b0;
      @(posedge clk_i);
    end
    start      <= 1'b1;
    func_i     <= op;
    key_i      <= k;
    value_i    <= v;
    position_i <= p;
    do @(posedge clk_i); while (busy);
    replies_owed.push_back(apply_table_op(op, k, v, p));
    op_tally[op]++;
  endtask

  // Hold off new commands until every owed reply has come back
  task automatic wait_until_drained();
    start <= 1'b0;
    do @(posedge clk_i); while (replies_owed.size() != 0);
  endtask

  task automatic test_empty_table();
    send_command(FUNC_GET, 32'h1234_5678, '0, '0);
    send_command(FUNC_DELETE, '1, '0, '0);
    send_command(FUNC_READ_AT, '0, '0, '0);
    send_command(FUNC_SPARE_HI, '1, '1, '1);
  endtask

  task automatic test_fill_and_overflow();
    logic [KEY_W-1:0] fill_keys [TABLE_DEPTH];
    int unsigned      i;
    for (i = 0; i < TABLE_DEPTH; i++) begin
      fill_keys[i] = (i == 0) ? '0 : (i == 1) ? '1 : {4'(i), 28'($urandom)};
      send_command(FUNC_SET, fill_keys[i], (i == 0) ? '1 : (i == 1) ? '0 : $urandom,
                   4'(i));
    end
    // full table: refuse a new key, still update an existing one
    send_command(FUNC_SET, 32'h0000_0001, $urandom, '0);
    send_command(FUNC_SET, fill_keys[7], $urandom, '0);
    send_command(FUNC_READ_AT, $urandom, '0, '1);
    // delete at the front to force the longest shift
    send_command(FUNC_DELETE, fill_keys[0], '0, '0);
    send_command(FUNC_READ_AT, '0, '0, '1);
    send_command(FUNC_GET, fill_keys[TABLE_DEPTH - 1], '0, '0);
    wait_until_drained();
  endtask

  task automatic test_clear_and_spare_codes();
    send_command(FUNC_CLEAR, 32'hDEAD_BEEF, '1, '1);
    send_command(FUNC_SPARE_LO, '0, '0, '0);
    send_command(FUNC_GET, '1, '0, '0);
  endtask

  task automatic test_random_traffic(input int unsigned n_cmds, input int unsigned idle_pct);
    logic [KEY_W-1:0]  pool [KEY_POOL];
    logic [KEY_W-1:0]  k;
    logic [FUNC_W-1:0] op;
    int unsigned       roll;
    int unsigned       issued;
    sender_idle_pct = idle_pct;
    issued = 0;
    foreach (pool[i]) pool[i] = $urandom;
    pool[0] = '0;
    pool[1] = '1;
    while (issued < n_cmds) begin
      if ($urandom_range(99) == 0) wait_until_drained();
      roll = $urandom_range(199);
      if (roll < 70) op = FUNC_SET;
      else if (roll < 108) op = FUNC_GET;
      else if (roll < 140) op = FUNC_DELETE;
      else if (roll < 190) op = FUNC_READ_AT;
      else if (roll < 193) op = FUNC_CLEAR;
      else op = FUNC_W'($urandom_range(FUNC_SPARE_HI, FUNC_SPARE_LO));
      k = ($urandom_range(99) < 85) ? pool[$urandom_range(KEY_POOL - 1)] : $urandom;
      send_command(op, k, $urandom, POS_W'($urandom_range(15)));
      if (op <= FUNC_READ_AT) issued++;
    end
    wait_until_drained();
  endtask

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
      mismatch_count++;
    end
  endtask

  // Compare each reply against the oldest owed one
  always @(posedge clk_i) begin
    table_reply_t want;
    if (rst_ni && done_o) begin
      if (replies_owed.size() == 0) begin
        $display("%0t: unexpected reply, expected none, actual key %h value %h",
                 $time, key_out_o, value_out_o);
        mismatch_count++;
      end else begin
        want = replies_owed.pop_front();
        check_field("hit", want.hit, hit_o);
        check_field("full_error", want.full_error, full_error_o);
        check_field("value_out", want.value, value_out_o);
        check_field("key_out", want.key, key_out_o);
        check_field("position_out", want.position, position_out_o);
        check_field("entry_count", want.count, entry_count_o);
        reply_total++;
        if (hit_o) hit_tally++;
        if (full_error_o) refusal_tally++;
      end
    end
  end

  // Bound the run length
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("%0t: timeout with %0d replies owed", $time, replies_owed.size());
      $display("Simulation FAILED");
      $finish;
    end
  end

  initial begin
    foreach (op_tally[i]) op_tally[i] = 0;
    foreach (kept_keys[i]) begin
      kept_keys[i] = '0;
      kept_vals[i] = '0;
    end
    apply_reset();
    test_empty_table();
    test_fill_and_overflow();
    test_clear_and_spare_codes();
    test_random_traffic(640, 32);
    test_random_traffic(640, 85);
    test_random_traffic(620, 0);
    start <= 1'b0;
    while (replies_owed.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    $display("Ran %0d set, %0d get, %0d delete, %0d clear, %0d read-at, %0d unknown-code commands",
             op_tally[FUNC_SET], op_tally[FUNC_GET], op_tally[FUNC_DELETE],
             op_tally[FUNC_CLEAR], op_tally[FUNC_READ_AT],
             op_tally[5] + op_tally[6] + op_tally[7]);
    $display("Checked %0d replies: %0d hits, %0d full-table refusals, %0d mismatches",
             reply_total, hit_tally, refusal_tally, mismatch_count);
    if (mismatch_count == 0 && replies_owed.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
